@@ src/glyph_bar_rasterizer_core_defines.svh @@
// assertion macros used by the rasterizer rtl
// expects signals named clock and reset in the module that uses them
`ifndef GLYPH_BAR_RASTERIZER_CORE_DEFINES_SVH
`define GLYPH_BAR_RASTERIZER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GBR_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");
`define GBR_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define GBR_ASSERT_ALWAYS(lbl, expr)
`define GBR_ASSERT_IMPLIES(lbl, ante, cons)
`endif
`endif

@@ src/gbr_pkg.sv @@
// shared types, constants and the 5x7 font table of the rasterizer
// no dependencies
package gbr_pkg;

   localparam int FRAME_WIDTH_DEF  = 128;
   localparam int FRAME_HEIGHT_DEF = 64;

   localparam logic [2:0] CMD_CLEAR      = 3'd0;
   localparam logic [2:0] CMD_PIXEL      = 3'd1;
   localparam logic [2:0] CMD_GLYPH_XY   = 3'd2;
   localparam logic [2:0] CMD_GLYPH_CURS = 3'd3;
   localparam logic [2:0] CMD_BAR        = 3'd4;
   localparam logic [2:0] CMD_READ       = 3'd5;

   localparam logic [9:0] CELL_ADVANCE = 10'd6;
   localparam logic [9:0] FULL_SCALE   = 10'd1000;
   localparam logic [15:0] RECIP       = 16'd33554;   // floor(2^25 / 1000)
   localparam int RECIP_SHIFT          = 25;
   localparam logic [7:0] GLYPH_FIRST  = 8'h20;
   localparam logic [7:0] GLYPH_LAST   = 8'h7A;
   localparam logic [6:0] GLYPH_QMARK  = 7'd31;

   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_PIXEL,
      OP_GLYPH,
      OP_BAR,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [9:0]  x;
      logic [9:0]  y;
      logic        on;
      logic [6:0]  glyph;
      logic [7:0]  w;
      logic [7:0]  h;
      logic [7:0]  filled;
      logic [2:0]  page;
      logic [6:0]  col;
   } cmd_type;

   typedef struct packed {
      logic init_busy;
   } status_type;

   typedef logic [0:6][4:0] font_glyph_type;

   function automatic font_glyph_type font_glyph(input logic [6:0] idx);
      font_glyph_type g;
      case (idx)
         7'd16: g = {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E};
         7'd17: g = {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E};
         7'd18: g = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F};
         7'd19: g = {5'h0E,5'h11,5'h01,5'h06,5'h01,5'h11,5'h0E};
         7'd20: g = {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02};
         7'd21: g = {5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E};
         7'd22: g = {5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E};
         7'd23: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08};
         7'd24: g = {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E};
         7'd25: g = {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C};
         7'd31: g = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04};
         7'd33: g = {5'h04,5'h0A,5'h11,5'h11,5'h1F,5'h11,5'h11};
         7'd34: g = {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E};
         7'd35: g = {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E};
         7'd36: g = {5'h1C,5'h12,5'h11,5'h11,5'h11,5'h12,5'h1C};
         7'd37: g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F};
         7'd38: g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10};
         7'd39: g = {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0E};
         7'd40: g = {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
         7'd41: g = {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E};
         7'd42: g = {5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C};
         7'd43: g = {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11};
         7'd44: g = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F};
         7'd45: g = {5'h11,5'h1B,5'h15,5'h11,5'h11,5'h11,5'h11};
         7'd46: g = {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11};
         7'd47: g = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
         7'd48: g = {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10};
         7'd49: g = {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D};
         7'd50: g = {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11};
         7'd51: g = {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E};
         7'd52: g = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04};
         7'd53: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
         7'd54: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04};
         7'd55: g = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11};
         7'd56: g = {5'h11,5'h0A,5'h04,5'h04,5'h04,5'h0A,5'h11};
         7'd57: g = {5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04,5'h04};
         7'd58: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F};
         7'd65: g = {5'h00,5'h00,5'h0E,5'h01,5'h0F,5'h11,5'h0F};
         7'd66: g = {5'h10,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h1E};
         7'd67: g = {5'h00,5'h00,5'h0E,5'h10,5'h10,5'h10,5'h0E};
         7'd68: g = {5'h01,5'h01,5'h0F,5'h11,5'h11,5'h11,5'h0F};
         7'd69: g = {5'h00,5'h00,5'h0E,5'h11,5'h1F,5'h10,5'h0E};
         7'd70: g = {5'h06,5'h08,5'h08,5'h1C,5'h08,5'h08,5'h08};
         7'd71: g = {5'h00,5'h0F,5'h11,5'h11,5'h0F,5'h01,5'h0E};
         7'd72: g = {5'h10,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h11};
         7'd73: g = {5'h04,5'h00,5'h0C,5'h04,5'h04,5'h04,5'h0E};
         7'd74: g = {5'h02,5'h00,5'h06,5'h02,5'h02,5'h12,5'h0C};
         7'd75: g = {5'h10,5'h10,5'h12,5'h14,5'h18,5'h14,5'h12};
         7'd76: g = {5'h0C,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E};
         7'd77: g = {5'h00,5'h00,5'h1A,5'h15,5'h15,5'h11,5'h11};
         7'd78: g = {5'h00,5'h00,5'h1E,5'h11,5'h11,5'h11,5'h11};
         7'd79: g = {5'h00,5'h00,5'h0E,5'h11,5'h11,5'h11,5'h0E};
         7'd80: g = {5'h00,5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10};
         7'd81: g = {5'h00,5'h0F,5'h11,5'h11,5'h0F,5'h01,5'h01};
         7'd82: g = {5'h00,5'h00,5'h16,5'h18,5'h10,5'h10,5'h10};
         7'd83: g = {5'h00,5'h00,5'h0F,5'h10,5'h0E,5'h01,5'h1E};
         7'd84: g = {5'h08,5'h08,5'h1C,5'h08,5'h08,5'h08,5'h06};
         7'd85: g = {5'h00,5'h00,5'h11,5'h11,5'h11,5'h11,5'h0F};
         7'd86: g = {5'h00,5'h00,5'h11,5'h11,5'h11,5'h0A,5'h04};
         7'd87: g = {5'h00,5'h00,5'h11,5'h11,5'h15,5'h15,5'h0A};
         7'd88: g = {5'h00,5'h00,5'h11,5'h0A,5'h04,5'h0A,5'h11};
         7'd89: g = {5'h00,5'h11,5'h11,5'h11,5'h0F,5'h01,5'h0E};
         7'd90: g = {5'h00,5'h00,5'h1F,5'h02,5'h04,5'h08,5'h1F};
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

@@ src/gbr_req_if.sv @@
// command channel of the rasterizer: valid/ready plus command fields
// no dependencies
interface gbr_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        cmd;
   logic signed [9:0] x;
   logic signed [9:0] y;
   logic              pixel_on;
   logic [7:0]        char_code;
   logic [7:0]        bar_width;
   logic [7:0]        bar_height;
   logic [9:0]        bar_permille;
   logic [2:0]        read_page;
   logic [6:0]        read_column;

   modport source (output valid, cmd, x, y, pixel_on, char_code, bar_width, bar_height,
                   bar_permille, read_page, read_column, input ready);
   modport sink (input valid, cmd, x, y, pixel_on, char_code, bar_width, bar_height,
                 bar_permille, read_page, read_column, output ready);
endinterface

@@ src/gbr_rsp_if.sv @@
// read-back channel of the rasterizer: valid/ready plus one byte
// no dependencies
interface gbr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;

   modport source (output valid, pixel_byte, input ready);
   modport sink (input valid, pixel_byte, output ready);
endinterface

@@ src/gbr_front.sv @@
// front end: takes command words, keeps the text cursor, works out the bar fill
// depends on gbr_pkg and gbr_req_if
module gbr_front (
   input  logic               clock,
   input  logic               reset,
   gbr_req_if.sink            req_ch,
   input  gbr_pkg::status_type status,
   output logic               push_valid,
   input  logic               push_ready,
   output gbr_pkg::cmd_type   push_data
);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_MUL  = 4'b0010,
      F_DIV  = 4'b0100,
      F_PUSH = 4'b1000
   } fstate_type;

   fstate_type       state_ff, state_in;
   gbr_pkg::cmd_type cmd_ff, cmd_in;
   logic [9:0]       cursor_x_ff, cursor_x_in;
   logic [9:0]       cursor_y_ff, cursor_y_in;
   logic [7:0]       wm2_ff, wm2_in;
   logic [9:0]       pms_ff, pms_in;
   logic [17:0]      prod_ff;
   logic [7:0]       q0_ff;
   logic             accept;
   logic [33:0]      recip_prod;
   logic [17:0]      remainder;

   assign req_ch.ready = (state_ff == F_IDLE) && !status.init_busy;
   assign accept       = req_ch.valid && req_ch.ready;
   assign recip_prod   = 34'(prod_ff) * 34'(gbr_pkg::RECIP);
   assign remainder    = prod_ff - 18'(q0_ff) * 18'(gbr_pkg::FULL_SCALE);

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      wm2_in      = wm2_ff;
      pms_in      = pms_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               cmd_in.x      = req_ch.x;
               cmd_in.y      = req_ch.y;
               cmd_in.on     = req_ch.pixel_on;
               cmd_in.w      = req_ch.bar_width;
               cmd_in.h      = req_ch.bar_height;
               cmd_in.filled = '0;
               cmd_in.page   = req_ch.read_page;
               cmd_in.col    = req_ch.read_column;
               if (req_ch.char_code < gbr_pkg::GLYPH_FIRST ||
                   req_ch.char_code > gbr_pkg::GLYPH_LAST) begin
                  cmd_in.glyph = gbr_pkg::GLYPH_QMARK;
               end else begin
                  cmd_in.glyph = 7'(req_ch.char_code - gbr_pkg::GLYPH_FIRST);
               end
               wm2_in = (req_ch.bar_width >= 8'd2) ? req_ch.bar_width - 8'd2 : 8'd0;
               pms_in = (req_ch.bar_permille > gbr_pkg::FULL_SCALE) ?
                        gbr_pkg::FULL_SCALE : req_ch.bar_permille;
               cmd_in.op = gbr_pkg::OP_CLEAR;
               state_in  = F_MUL;
               unique case (req_ch.cmd)
                  gbr_pkg::CMD_CLEAR: cmd_in.op = gbr_pkg::OP_CLEAR;
                  gbr_pkg::CMD_PIXEL: cmd_in.op = gbr_pkg::OP_PIXEL;
                  gbr_pkg::CMD_GLYPH_XY: begin
                     cmd_in.op   = gbr_pkg::OP_GLYPH;
                     cursor_x_in = req_ch.x + gbr_pkg::CELL_ADVANCE;
                     cursor_y_in = req_ch.y;
                  end
                  gbr_pkg::CMD_GLYPH_CURS: begin
                     cmd_in.op   = gbr_pkg::OP_GLYPH;
                     cmd_in.x    = cursor_x_ff;
                     cmd_in.y    = cursor_y_ff;
                     cursor_x_in = cursor_x_ff + gbr_pkg::CELL_ADVANCE;
                  end
                  gbr_pkg::CMD_BAR:  cmd_in.op = gbr_pkg::OP_BAR;
                  gbr_pkg::CMD_READ: cmd_in.op = gbr_pkg::OP_READ;
                  default: state_in = F_IDLE;   // unused codes are dropped
               endcase
            end
         end
         F_MUL:  state_in = F_DIV;
         F_DIV:  state_in = F_PUSH;
         F_PUSH: begin
            // reciprocal estimate is low by at most one
            cmd_in.filled = q0_ff + ((remainder >= 18'(gbr_pkg::FULL_SCALE)) ? 8'd1 : 8'd0);
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
      end else begin
         state_ff    <= state_in;
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
      end
      cmd_ff  <= cmd_in;
      wm2_ff  <= wm2_in;
      pms_ff  <= pms_in;
      prod_ff <= 18'(wm2_ff) * 18'(pms_ff);
      q0_ff   <= 8'(recip_prod >> gbr_pkg::RECIP_SHIFT);
   end

   assign push_valid = (state_ff == F_PUSH);
   assign push_data  = cmd_in;

endmodule

@@ src/gbr_queue.sv @@
// two-entry command queue between front and back end
// depends on gbr_pkg
module gbr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  gbr_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output gbr_pkg::cmd_type pop_data
);

   gbr_pkg::cmd_type entries_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
      end
      if (push) entries_ff[wr_ptr_ff] <= push_data;
   end

endmodule

@@ src/gbr_back.sv @@
// back end: frame store, pixel sequencer with read-modify-write, read-back word
// depends on gbr_pkg, gbr_rsp_if and the assertion macro header
`include "glyph_bar_rasterizer_core_defines.svh"
module gbr_back #(
   parameter int FRAME_WIDTH  = gbr_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = gbr_pkg::FRAME_HEIGHT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  gbr_pkg::cmd_type    pop_data,
   output gbr_pkg::status_type status,
   gbr_rsp_if.source           rsp_ch
);

   localparam int PAGES  = (FRAME_HEIGHT + 7) / 8;
   localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int COL_W  = $clog2(FRAME_WIDTH);
   localparam int ADDR_W = PAGE_W + COL_W;
   localparam int DEPTH  = 2 ** ADDR_W;

   typedef enum logic [5:0] {
      B_CLEAR = 6'b000001,
      B_IDLE  = 6'b000010,
      B_GEN   = 6'b000100,
      B_RMW   = 6'b001000,
      B_READ  = 6'b010000,
      B_RESP  = 6'b100000
   } bstate_type;

   typedef enum logic [6:0] {
      P_PIXEL = 7'b0000001,
      P_GLYPH = 7'b0000010,
      P_TOP   = 7'b0000100,
      P_BOT   = 7'b0001000,
      P_LEFT  = 7'b0010000,
      P_RIGHT = 7'b0100000,
      P_FILL  = 7'b1000000
   } phase_type;

   logic [7:0]       mem [DEPTH];
   logic [7:0]       rd_ff;
   logic             we;
   logic [ADDR_W-1:0] waddr, raddr;
   logic [7:0]       wdata;

   bstate_type        state_ff, state_in;
   phase_type         phase_ff, phase_in, phase_next;
   gbr_pkg::cmd_type  cur_ff, cur_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [7:0]        i_ff, i_in, j_ff, j_in;
   logic [ADDR_W-1:0] pix_addr_ff, pix_addr_in;
   logic [7:0]        mask_ff, mask_in;
   logic              on_ff, on_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              init_ff, init_in;

   logic [7:0]        ni, jlast;
   logic              nonempty, phase_end, final_phase, in_frame, pix_on, read_in_range;
   logic [10:0]       dx, dy;
   logic [11:0]       px, py;
   logic [ADDR_W-1:0] gen_addr, read_addr;
   gbr_pkg::font_glyph_type glyph_rows;
   logic [4:0]        glyph_row;

   assign glyph_rows = gbr_pkg::font_glyph(cur_ff.glyph);
   assign glyph_row  = glyph_rows[j_ff[2:0]];

   // per-phase loop bounds and pixel offsets
   always_comb begin
      ni = 8'd0; jlast = 8'd0; dx = '0; dy = '0; phase_next = P_FILL; final_phase = 1'b1;
      pix_on = 1'b1;
      unique case (phase_ff)
         P_PIXEL: begin
            ni = 8'd1; pix_on = cur_ff.on;
         end
         P_GLYPH: begin
            ni = 8'd5; jlast = 8'd6; dx = 11'(i_ff); dy = 11'(j_ff);
            pix_on = glyph_row[3'd4 - i_ff[2:0]];
         end
         P_TOP: begin
            ni = cur_ff.w; dx = 11'(i_ff); phase_next = P_BOT; final_phase = 1'b0;
         end
         P_BOT: begin
            ni = cur_ff.w; dx = 11'(i_ff); dy = 11'(cur_ff.h) - 11'd1;
            phase_next = P_LEFT; final_phase = 1'b0;
         end
         P_LEFT: begin
            ni = cur_ff.h; dy = 11'(i_ff); phase_next = P_RIGHT; final_phase = 1'b0;
         end
         P_RIGHT: begin
            ni = cur_ff.h; dx = 11'(cur_ff.w) - 11'd1; dy = 11'(i_ff);
            phase_next = P_FILL; final_phase = 1'b0;
         end
         P_FILL: begin
            ni = cur_ff.filled; jlast = cur_ff.h - 8'd2;
            dx = 11'(i_ff) + 11'd1; dy = 11'(j_ff);
         end
         default: ;
      endcase
   end

   assign nonempty  = (ni != 8'd0) && !(phase_ff == P_FILL && cur_ff.h < 8'd3);
   assign phase_end = (j_ff == jlast) && (i_ff == ni - 8'd1);
   assign px = {{2{cur_ff.x[9]}}, cur_ff.x} + {dx[10], dx};
   assign py = {{2{cur_ff.y[9]}}, cur_ff.y} + {dy[10], dy};
   assign in_frame = !px[11] && !py[11] && (px < 12'(FRAME_WIDTH)) &&
                     (py < 12'(FRAME_HEIGHT));
   assign gen_addr = {PAGE_W'(py[11:3]), COL_W'(px)};
   assign read_in_range = (32'(cur_ff.page) < PAGES) && (32'(cur_ff.col) < FRAME_WIDTH);
   assign read_addr = {PAGE_W'(cur_ff.page), COL_W'(cur_ff.col)};

   // the sweep that follows reset holds off the command channel
   assign init_in = init_ff && !(state_ff == B_CLEAR && clr_ff == ADDR_W'(DEPTH - 1));

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      cur_in       = cur_ff;
      clr_in       = clr_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pix_addr_in  = pix_addr_ff;
      mask_in      = mask_ff;
      on_in        = on_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      pop_ready    = 1'b0;
      we           = 1'b0;
      waddr        = pix_addr_ff;
      wdata        = on_ff ? (rd_ff | mask_ff) : (rd_ff & ~mask_ff);
      raddr        = read_addr;
      unique case (state_ff)
         B_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff;
            wdata  = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) state_in = B_IDLE;
         end
         B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cur_in = pop_data;
               clr_in = '0;
               i_in   = '0;
               j_in   = '0;
               unique case (pop_data.op)
                  gbr_pkg::OP_CLEAR: state_in = B_CLEAR;
                  gbr_pkg::OP_READ:  state_in = B_READ;
                  gbr_pkg::OP_PIXEL: begin
                     phase_in = P_PIXEL; state_in = B_GEN;
                  end
                  gbr_pkg::OP_GLYPH: begin
                     phase_in = P_GLYPH; state_in = B_GEN;
                  end
                  gbr_pkg::OP_BAR: begin
                     phase_in = P_TOP; state_in = B_GEN;
                  end
                  default: state_in = B_IDLE;
               endcase
            end
         end
         B_GEN: begin
            raddr = gen_addr;
            if (nonempty) begin
               pix_addr_in = gen_addr;
               mask_in     = 8'(1) << py[2:0];
               on_in       = pix_on;
               last_in     = phase_end && final_phase;
               if (in_frame) state_in = B_RMW;
               else if (phase_end && final_phase) state_in = B_IDLE;
               if (phase_end) begin
                  phase_in = phase_next;
                  i_in     = '0;
                  j_in     = (phase_next == P_FILL) ? 8'd1 : 8'd0;
               end else if (j_ff == jlast) begin
                  i_in = i_ff + 8'd1;
                  j_in = (phase_ff == P_FILL) ? 8'd1 : 8'd0;
               end else begin
                  j_in = j_ff + 8'd1;
               end
            end else begin
               // empty loop: step past it
               phase_in = phase_next;
               i_in     = '0;
               j_in     = (phase_next == P_FILL) ? 8'd1 : 8'd0;
               if (final_phase) state_in = B_IDLE;
            end
         end
         B_RMW: begin
            we       = 1'b1;
            state_in = last_ff ? B_IDLE : B_GEN;
         end
         B_READ: state_in = B_RESP;
         B_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = read_in_range ? rd_ff : 8'd0;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         phase_ff     <= P_PIXEL;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         init_ff      <= 1'b1;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         init_ff      <= init_in;
      end
      cur_ff      <= cur_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      pix_addr_ff <= pix_addr_in;
      mask_ff     <= mask_in;
      on_ff       <= on_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.init_busy = init_ff;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.pixel_byte = rsp_data_ff;

   `GBR_ASSERT_IMPLIES(a_rmw_after_gen, state_ff == B_RMW, $past(state_ff) == B_GEN)
   `GBR_ASSERT_IMPLIES(a_rsp_from_read, $rose(rsp_valid_ff), $past(state_ff) == B_RESP)
   `GBR_ASSERT_IMPLIES(a_pop_only_idle, pop_ready, state_ff == B_IDLE)
   `GBR_ASSERT_IMPLIES(a_write_states, we, state_ff == B_RMW || state_ff == B_CLEAR)

endmodule

@@ src/glyph_bar_rasterizer_core.sv @@
// Rasterizer for a 1-bit page-organized framebuffer (bit n of a byte is row page*8+n).
// Commands arrive one word at a time on req_ch (valid/ready); a read-back command
// returns one word on rsp_ch, every other command returns nothing.
// The front end takes a word through decode, fill multiply, reciprocal multiply
// and queue push, and takes no new word until the push is done. A two-word queue
// lets the front take the next command while the back end draws.
// The back end sets pixels by read-modify-write on the frame store, which has one
// read and one write port: an in-frame pixel is read in the generate state and
// written in the read-modify-write state, a clipped pixel is only generated. A clear
// sweeps 2^(clog2(pages)+clog2(width)) addresses (1024 at 128x64); a read-back goes
// through the read and response states to the output register.
// After reset the store is swept to zero as by a clear; req_ch.ready stays low
// meanwhile. The cursor starts at 0,0.
// A stalled read-back word waits in the output register; the back end holds only
// at the next read-back, and the front keeps taking words until the queue fills.
// depends on gbr_pkg, gbr_req_if, gbr_rsp_if, gbr_front, gbr_queue, gbr_back
module glyph_bar_rasterizer_core #(
   parameter int FRAME_WIDTH  = gbr_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = gbr_pkg::FRAME_HEIGHT_DEF
) (
   input logic       clock,
   input logic       reset,
   gbr_req_if.sink   req_ch,
   gbr_rsp_if.source rsp_ch
);

   gbr_pkg::cmd_type    push_data, pop_data;
   gbr_pkg::status_type status;
   logic                push_valid, push_ready, pop_valid, pop_ready;

   gbr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .status     (status),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   gbr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   gbr_back #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .status    (status),
      .rsp_ch    (rsp_ch)
   );

endmodule

@@ tb/tb.sv @@
// self-checking testbench of glyph_bar_rasterizer_core: random and directed drawing words
// are checked against a behavioral framebuffer that is kept in step with every accepted word
// depends on gbr_pkg, gbr_req_if, gbr_rsp_if and the rasterizer rtl
`timescale 1ns / 100ps

module tb;

   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;
   localparam int FB_W = 128;
   localparam int FB_H = 64;
   localparam int IDLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 2000;
   localparam int RANDOM_WORDS = 1900;

   typedef struct {
      logic [2:0]        cmd;
      logic signed [9:0] x;
      logic signed [9:0] y;
      logic              on;
      logic [7:0]        code;
      logic [7:0]        w;
      logic [7:0]        h;
      logic [9:0]        pm;
      logic [2:0]        page;
      logic [6:0]        col;
   } draw_word_type;

   logic clock;
   logic reset;

   gbr_req_if req_ch();
   gbr_rsp_if rsp_ch();

   glyph_bar_rasterizer_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // behavioral framebuffer, cursor and font
   logic [7:0]  fb_bytes [0:8*FB_W-1];
   logic [9:0]  text_x;
   logic [9:0]  text_y;
   logic [55:0] font_rows [0:90];

   draw_word_type pending_words [$];
   logic [7:0]  expected_bytes [$];
   draw_word_type on_bus;
   bit          word_taken;
   bit          byte_taken;
   int          words_sent;
   int          words_taken;
   int          err_count;
   int          idle_cycles;
   int          send_gap;
   int          take_stall;
   int          calm_left;

   function automatic void plot(int px, int py, bit lit);
      int at;
      if (px < 0 || px >= FB_W || py < 0 || py >= FB_H) return;
      at = (py / 8) * FB_W + px;
      fb_bytes[at][py % 8] = lit;
   endfunction

   function automatic void plot_glyph(int gx, int gy, logic [7:0] code);
      logic [55:0] rows;
      logic [7:0]  c;
      c = (code < gbr_pkg::GLYPH_FIRST || code > gbr_pkg::GLYPH_LAST) ? 8'h3F : code;
      rows = font_rows[c - 8'h20];
      for (int r = 0; r < 7; r++)
         for (int k = 0; k < 5; k++)
            plot(gx + k, gy + r, rows[55 - 8*r - 3 - k]);
   endfunction

   function automatic void plot_bar(int bx, int by, int w, int h, int pm);
      int filled;
      for (int i = 0; i < w; i++) begin
         plot(bx + i, by, 1);
         plot(bx + i, by + h - 1, 1);
      end
      for (int i = 0; i < h; i++) begin
         plot(bx, by + i, 1);
         plot(bx + w - 1, by + i, 1);
      end
      if (pm > 1000) pm = 1000;
      filled = (w >= 2) ? ((w - 2) * pm) / 1000 : 0;
      for (int i = 0; i < filled; i++)
         for (int j = 1; j < h - 1; j++)
            plot(bx + 1 + i, by + j, 1);
   endfunction

   // applies one word to the framebuffer, queues the byte a read returns
   function automatic void rasterize_word(draw_word_type d);
      case (d.cmd)
         gbr_pkg::CMD_CLEAR: begin
            foreach (fb_bytes[i]) fb_bytes[i] = 8'h00;
         end
         gbr_pkg::CMD_PIXEL: plot(int'(d.x), int'(d.y), d.on);
         gbr_pkg::CMD_GLYPH_XY: begin
            plot_glyph(int'(d.x), int'(d.y), d.code);
            text_x = d.x + gbr_pkg::CELL_ADVANCE;
            text_y = d.y;
         end
         gbr_pkg::CMD_GLYPH_CURS: begin
            plot_glyph(int'($signed(text_x)), int'($signed(text_y)), d.code);
            text_x = text_x + gbr_pkg::CELL_ADVANCE;
         end
         gbr_pkg::CMD_BAR: plot_bar(int'(d.x), int'(d.y), int'(d.w), int'(d.h), int'(d.pm));
         gbr_pkg::CMD_READ: expected_bytes.push_back(fb_bytes[d.page * FB_W + d.col]);
         default: ;
      endcase
   endfunction

   function automatic logic signed [9:0] pick_coord(int hi);
      int v;
      if ($urandom_range(0, 99) < 85) v = int'($urandom_range(0, hi + 12)) - 8;
      else v = int'($urandom_range(0, 1023)) - 512;
      return v[9:0];
   endfunction

   function automatic draw_word_type random_word();
      draw_word_type d;
      int roll;
      d.cmd  = 3'($urandom);
      d.x    = 10'($urandom);
      d.y    = 10'($urandom);
      d.on   = 1'($urandom);
      d.code = 8'($urandom);
      d.w    = 8'($urandom);
      d.h    = 8'($urandom);
      d.pm   = 10'($urandom);
      d.page = 3'($urandom);
      d.col  = 7'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 2) d.cmd = gbr_pkg::CMD_CLEAR;
      else if (roll < 26) d.cmd = gbr_pkg::CMD_PIXEL;
      else if (roll < 42) d.cmd = gbr_pkg::CMD_GLYPH_XY;
      else if (roll < 60) d.cmd = gbr_pkg::CMD_GLYPH_CURS;
      else if (roll < 70) d.cmd = gbr_pkg::CMD_BAR;
      else if (roll < 98) d.cmd = gbr_pkg::CMD_READ;
      else d.cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
      if (d.cmd != gbr_pkg::CMD_READ && $urandom_range(0, 9) != 0) begin
         d.x = pick_coord(FB_W);
         d.y = pick_coord(FB_H);
      end
      // mostly printable text, now and then a byte outside the font
      if ($urandom_range(0, 9) < 8) d.code = 8'($urandom_range(32, 122));
      if (d.cmd == gbr_pkg::CMD_BAR) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) d.h = 8'($urandom_range(0, 10));
         else if (roll < 6) d.w = 8'($urandom_range(0, 10));
         else begin
            d.w = 8'($urandom_range(0, 24));
            d.h = 8'($urandom_range(0, 20));
         end
         if ($urandom_range(0, 3) == 0) d.pm = 10'($urandom_range(990, 1023));
      end
      return d;
   endfunction

   function automatic draw_word_type make_word(logic [2:0] cmd, int x, int y, logic [7:0] code,
                                               int w, int h, int pm, int page, int col);
      draw_word_type d;
      d.cmd = cmd;
      d.x = x[9:0];
      d.y = y[9:0];
      d.on = 1'b1;
      d.code = code;
      d.w = w[7:0];
      d.h = h[7:0];
      d.pm = pm[9:0];
      d.page = page[2:0];
      d.col = col[6:0];
      return d;
   endfunction

   function automatic int draw_wait();
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(10, 60);
      return $urandom_range(0, 17);
   endfunction

   // command driver, changes at the falling edge
   always @(negedge clock) begin
      logic next_valid;
      draw_word_type d;
      next_valid = req_ch.valid;
      if (!reset) begin
         if (word_taken || !req_ch.valid) begin
            word_taken = 0;
            next_valid = 1'b0;
            if (send_gap > 0) send_gap--;
            else if (pending_words.size() > 0) begin
               d = pending_words.pop_front();
               on_bus = d;
               req_ch.cmd          <= d.cmd;
               req_ch.x            <= d.x;
               req_ch.y            <= d.y;
               req_ch.pixel_on     <= d.on;
               req_ch.char_code    <= d.code;
               req_ch.bar_width    <= d.w;
               req_ch.bar_height   <= d.h;
               req_ch.bar_permille <= d.pm;
               req_ch.read_page    <= d.page;
               req_ch.read_column  <= d.col;
               next_valid = 1'b1;
               words_sent++;
               send_gap = draw_wait();
            end
         end
         if (byte_taken) begin
            byte_taken = 0;
            take_stall = draw_wait();
         end
         if (take_stall > 0) take_stall--;
         rsp_ch.ready <= (take_stall == 0);
      end
      req_ch.valid <= next_valid;
   end

   // monitor and watchdog, sampled at the rising edge
   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset) begin
         idle_cycles++;
         if (req_ch.valid && req_ch.ready) begin
            rasterize_word(on_bus);
            word_taken = 1;
            words_taken++;
            idle_cycles = 0;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            byte_taken = 1;
            idle_cycles = 0;
            if (expected_bytes.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("unexpected read word: pixel_byte=%02h", rsp_ch.pixel_byte);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_ch.pixel_byte !== want) begin
                  err_count++;
                  if (err_count <= 10)
                     $display("pixel_byte mismatch: expected %02h actual %02h",
                              want, rsp_ch.pixel_byte);
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      foreach (font_rows[i]) font_rows[i] = 56'h0;
      font_rows[16] = 56'h0E11131519110E; font_rows[17] = 56'h040C040404040E;
      font_rows[18] = 56'h0E11010204081F; font_rows[19] = 56'h0E11010601110E;
      font_rows[20] = 56'h02060A121F0202; font_rows[21] = 56'h1F101E0101110E;
      font_rows[22] = 56'h0608101E11110E; font_rows[23] = 56'h1F010204080808;
      font_rows[24] = 56'h0E11110E11110E; font_rows[25] = 56'h0E11110F01020C;
      font_rows[31] = 56'h0E110102040004; font_rows[33] = 56'h040A11111F1111;
      font_rows[34] = 56'h1E11111E11111E; font_rows[35] = 56'h0E11101010110E;
      font_rows[36] = 56'h1C12111111121C; font_rows[37] = 56'h1F10101E10101F;
      font_rows[38] = 56'h1F10101E101010; font_rows[39] = 56'h0E11101711110E;
      font_rows[40] = 56'h1111111F111111; font_rows[41] = 56'h0E04040404040E;
      font_rows[42] = 56'h0702020202120C; font_rows[43] = 56'h11121418141211;
      font_rows[44] = 56'h1010101010101F; font_rows[45] = 56'h111B1511111111;
      font_rows[46] = 56'h11191513111111; font_rows[47] = 56'h0E11111111110E;
      font_rows[48] = 56'h1E11111E101010; font_rows[49] = 56'h0E11111115120D;
      font_rows[50] = 56'h1E11111E141211; font_rows[51] = 56'h0F10100E01011E;
      font_rows[52] = 56'h1F040404040404; font_rows[53] = 56'h1111111111110E;
      font_rows[54] = 56'h11111111110A04; font_rows[55] = 56'h11111115151B11;
      font_rows[56] = 56'h110A0404040A11; font_rows[57] = 56'h110A0404040404;
      font_rows[58] = 56'h1F01020408101F; font_rows[65] = 56'h00000E010F110F;
      font_rows[66] = 56'h10101E1111111E; font_rows[67] = 56'h00000E1010100E;
      font_rows[68] = 56'h01010F1111110F; font_rows[69] = 56'h00000E111F100E;
      font_rows[70] = 56'h0608081C080808; font_rows[71] = 56'h000F11110F010E;
      font_rows[72] = 56'h10101E11111111; font_rows[73] = 56'h04000C0404040E;
      font_rows[74] = 56'h0200060202120C; font_rows[75] = 56'h10101214181412;
      font_rows[76] = 56'h0C04040404040E; font_rows[77] = 56'h00001A15151111;
      font_rows[78] = 56'h00001E11111111; font_rows[79] = 56'h00000E1111110E;
      font_rows[80] = 56'h001E11111E1010; font_rows[81] = 56'h000F11110F0101;
      font_rows[82] = 56'h00001618101010; font_rows[83] = 56'h00000F100E011E;
      font_rows[84] = 56'h08081C08080806; font_rows[85] = 56'h0000111111110F;
      font_rows[86] = 56'h00001111110A04; font_rows[87] = 56'h0000111115150A;
      font_rows[88] = 56'h0000110A040A11; font_rows[89] = 56'h001111110F010E;
      font_rows[90] = 56'h00001F0204081F;
      foreach (fb_bytes[i]) fb_bytes[i] = 8'h00;
      text_x = '0;
      text_y = '0;
      word_taken = 0;
      byte_taken = 0;
      words_sent = 0;
      words_taken = 0;
      err_count = 0;
      idle_cycles = 0;
      send_gap = 0;
      take_stall = 0;
      calm_left = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd = gbr_pkg::CMD_CLEAR;
      req_ch.x = '0;
      req_ch.y = '0;
      req_ch.pixel_on = 1'b0;
      req_ch.char_code = '0;
      req_ch.bar_width = '0;
      req_ch.bar_height = '0;
      req_ch.bar_permille = '0;
      req_ch.read_page = '0;
      req_ch.read_column = '0;
      rsp_ch.ready = 1'b0;

      // directed words: corners, clipping, font edge cases, degenerate bars
      pending_words.push_back(make_word(gbr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_PIXEL, 127, 63, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_PIXEL, -512, 511, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_PIXEL, 511, -512, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 7, 127));
      pending_words.push_back(make_word(gbr_pkg::CMD_GLYPH_XY, -2, -3, 8'h41, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_GLYPH_CURS, 0, 0, 8'h00, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_GLYPH_CURS, 0, 0, 8'hFF, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_GLYPH_CURS, 0, 0, 8'h7B, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_GLYPH_CURS, 0, 0, 8'h3A, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_GLYPH_XY, 124, 60, 8'h7A, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_GLYPH_XY, 508, 8, 8'h20, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_GLYPH_CURS, 0, 0, 8'h3F, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_BAR, 3, 20, 0, 0, 0, 500, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_BAR, 10, 30, 0, 1, 5, 1000, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_BAR, 20, 40, 0, 30, 10, 1023, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_BAR, -512, -512, 0, 255, 255, 333, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 3, 3));
      pending_words.push_back(make_word(gbr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 5, 25));
      pending_words.push_back(make_word(CMD_SPARE_6, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(CMD_SPARE_7, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_GLYPH_CURS, 0, 0, 8'h30, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(gbr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
      for (int n = 0; n < RANDOM_WORDS; n++) pending_words.push_back(random_word());

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (pending_words.size() == 0 && words_taken == words_sent);
      wait (expected_bytes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0 && expected_bytes.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+src
src/gbr_pkg.sv
src/gbr_req_if.sv
src/gbr_rsp_if.sv
src/gbr_front.sv
src/gbr_queue.sv
src/gbr_back.sv
src/glyph_bar_rasterizer_core.sv
tb/tb.sv
